// File: design/landau_polynomial_energy_gradient_macros.svh
// ----------------------------------------------------------------------------
// landau polynomial energy gradient assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LANDAU_POLYNOMIAL_ENERGY_GRADIENT_MACROS_SVH
`define LANDAU_POLYNOMIAL_ENERGY_GRADIENT_MACROS_SVH

// same-cycle implication
`define LPEG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPEG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lpeg_pkg.sv
// ----------------------------------------------------------------------------
// lpeg_pkg
// shared widths, request codes and lane control types
// ----------------------------------------------------------------------------
`default_nettype none

package lpeg_pkg;

    localparam int VECTOR_DIM_DEF = 3;

    localparam int COEF_W  = 32;
    localparam int P_W     = 16;
    localparam int MONO_W  = 17;
    localparam int WGT_W   = 19;
    localparam int PROD_W  = COEF_W + WGT_W;
    localparam int ACC_W   = 57;
    localparam int NLANES  = 4;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 232;

    localparam logic [1:0] REQ_WR_R2 = 2'd0;
    localparam logic [1:0] REQ_WR_R4 = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    // lane order
    localparam int LANE_QE = 0;
    localparam int LANE_FE = 1;
    localparam int LANE_QG = 2;
    localparam int LANE_FG = 3;

    typedef struct packed {
        logic clear;
        logic valid;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
    } lane_stat_t;

endpackage

`default_nettype wire

// File: design/lpeg_ram.sv
// ----------------------------------------------------------------------------
// lpeg_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lpeg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: design/lpeg_lane.sv
// ----------------------------------------------------------------------------
// lpeg_lane
// one multiply-accumulate lane: coefficient times weight into an exact sum
// ----------------------------------------------------------------------------
`default_nettype none

module lpeg_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire lpeg_pkg::lane_ctrl_t                 ctrl,
    input  wire logic signed [lpeg_pkg::COEF_W-1:0]   coef,
    input  wire logic signed [lpeg_pkg::WGT_W-1:0]    wgt,
    output logic signed      [lpeg_pkg::ACC_W-1:0]    acc,
    output lpeg_pkg::lane_stat_t                      stat
);

    localparam int EXT_W = lpeg_pkg::ACC_W - lpeg_pkg::PROD_W;

    logic signed [lpeg_pkg::PROD_W-1:0] prod_reg;
    logic                               pv_reg;
    logic signed [lpeg_pkg::ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= coef * wgt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            pv_reg <= ctrl.valid;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (pv_reg) begin
                acc_reg <= acc_reg + {{EXT_W{prod_reg[lpeg_pkg::PROD_W-1]}}, prod_reg};
            end
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = pv_reg;

endmodule

`default_nettype wire

// File: design/lpeg_merge.sv
// ----------------------------------------------------------------------------
// lpeg_merge
// collects the four lane sums into the result register and the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module lpeg_merge (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   load,
    input  wire logic signed [lpeg_pkg::ACC_W-1:0]      qe,
    input  wire logic signed [lpeg_pkg::ACC_W-1:0]      fe,
    input  wire logic signed [lpeg_pkg::ACC_W-1:0]      qg,
    input  wire logic signed [lpeg_pkg::ACC_W-1:0]      fg,
    output logic                                        free,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [lpeg_pkg::OUT_TDATA_W-1:0]            m_tdata
);

    localparam int PAD_W = lpeg_pkg::OUT_TDATA_W - 4 * lpeg_pkg::ACC_W;

    logic                                valid_reg;
    logic [lpeg_pkg::OUT_TDATA_W-1:0]    data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{PAD_W{1'b0}}, fg, qg, fe, qe};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// File: design/landau_polynomial_energy_gradient.sv
// ----------------------------------------------------------------------------
// landau_polynomial_energy_gradient
// quadratic and quartic tensor energies of a vector, with their derivatives
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit up)                 | tuser
//  s_axis   | in        | coef_index, coef_value, p_x, p_y, p_z,    | req_type
//           |           | grad_component                            |
//  m_axis   | out       | quad_energy, quartic_energy, quad_grad,   | -
//           |           | quartic_grad                              |
//
//  a write transaction updates the store at acceptance
//  an evaluate reads one coefficient per cycle, rank-two entries from flops
//  first, then rank-four entries from the ram; then the lane pipeline drains
//  the result waits in an output register; writes and a new evaluate are taken
//  while it waits, and a finished evaluate holds until the register is free
//  reset clears both stores (rank-four entries by valid bits) and all control
// ----------------------------------------------------------------------------
`default_nettype none

module landau_polynomial_energy_gradient #(
    parameter int VECTOR_DIM = lpeg_pkg::VECTOR_DIM_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // coef_index[6:0], coef_value[38:7], p_x[54:39], p_y[70:55], p_z[86:71],
    // grad_component[88:87], zeros above
    input  wire logic [lpeg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  wire logic [lpeg_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // quad_energy[56:0], quartic_energy[113:57], quad_grad[170:114],
    // quartic_grad[227:171], zeros above
    output logic [lpeg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    `include "landau_polynomial_energy_gradient_macros.svh"

    localparam int D      = VECTOR_DIM;
    localparam int DEPTH2 = D * D;
    localparam int DEPTH4 = DEPTH2 * DEPTH2;
    localparam int IDX2_W = $clog2(DEPTH2);
    localparam int IDX4_W = $clog2(DEPTH4);
    localparam int DW     = (D > 1) ? $clog2(D) : 1;
    localparam int CW     = lpeg_pkg::COEF_W;
    localparam int PW     = lpeg_pkg::P_W;
    localparam int MW     = lpeg_pkg::MONO_W;
    localparam int WW     = lpeg_pkg::WGT_W;

    localparam logic [DW-1:0]     DIG_LAST = DW'(D - 1);
    localparam logic [IDX4_W-1:0] IDX_LAST = IDX4_W'(DEPTH4 - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    // input field unpacking
    logic [1:0]            req_type;
    logic [6:0]            coef_index;
    logic signed [CW-1:0]  coef_value;
    logic signed [PW-1:0]  p_in [3];
    logic [1:0]            grad_component;

    assign req_type       = s_axis_tuser[1:0];
    assign coef_index     = s_axis_tdata[6:0];
    assign coef_value     = s_axis_tdata[38:7];
    assign p_in[0]        = s_axis_tdata[54:39];
    assign p_in[1]        = s_axis_tdata[70:55];
    assign p_in[2]        = s_axis_tdata[86:71];
    assign grad_component = s_axis_tdata[88:87];

    state_t state_reg, state_next;

    logic acc_in;
    logic wr_r2, wr_r4, eval_start;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign wr_r2 = acc_in && (req_type == lpeg_pkg::REQ_WR_R2) && (coef_index < 7'(DEPTH2));
    assign wr_r4 = acc_in && (req_type == lpeg_pkg::REQ_WR_R4) && (coef_index < 7'(DEPTH4));
    assign eval_start = acc_in && (req_type == lpeg_pkg::REQ_EVAL);

    // rank-two store in flops, rank-four store in ram with valid bits
    logic signed [CW-1:0] r2_reg [DEPTH2];
    logic                 r4v_reg [DEPTH4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH2; i++) begin
                r2_reg[i] <= '0;
            end
            for (int i = 0; i < DEPTH4; i++) begin
                r4v_reg[i] <= 1'b0;
            end
        end else begin
            if (wr_r2) begin
                r2_reg[coef_index[IDX2_W-1:0]] <= coef_value;
            end
            if (wr_r4) begin
                r4v_reg[coef_index[IDX4_W-1:0]] <= 1'b1;
            end
        end
    end

    // operand latch for the evaluate
    logic signed [PW-1:0] p_reg [D];
    logic [1:0]           m_reg;

    always_ff @(posedge aclk) begin
        if (eval_start) begin
            for (int i = 0; i < D; i++) begin
                p_reg[i] <= p_in[i];
            end
            m_reg <= grad_component;
        end
    end

    // entry sequencer: rank-two entries first, then rank-four entries
    logic [IDX4_W-1:0] idx_reg;
    logic [DW-1:0]     a_reg, b_reg, c_reg, d_reg;
    logic              ph4_reg;
    logic              issue, issue_last;

    assign issue      = (state_reg == ST_RUN);
    assign issue_last = issue && ph4_reg && (idx_reg == IDX_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
            c_reg   <= '0;
            d_reg   <= '0;
            ph4_reg <= 1'b0;
        end else if (eval_start) begin
            idx_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
            c_reg   <= '0;
            d_reg   <= '0;
            ph4_reg <= 1'b0;
        end else if (issue) begin
            if (!ph4_reg) begin
                if (b_reg == DIG_LAST) begin
                    b_reg <= '0;
                    if (a_reg == DIG_LAST) begin
                        // rank-two sweep done, restart the index for rank four
                        a_reg   <= '0;
                        idx_reg <= '0;
                        ph4_reg <= 1'b1;
                    end else begin
                        a_reg   <= a_reg + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end else begin
                    b_reg   <= b_reg + 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
            end else begin
                idx_reg <= idx_reg + 1'b1;
                if (d_reg == DIG_LAST) begin
                    d_reg <= '0;
                    if (c_reg == DIG_LAST) begin
                        c_reg <= '0;
                        if (b_reg == DIG_LAST) begin
                            b_reg <= '0;
                            a_reg <= a_reg + 1'b1;
                        end else begin
                            b_reg <= b_reg + 1'b1;
                        end
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end else begin
                    d_reg <= d_reg + 1'b1;
                end
            end
        end
    end

    // stage 1: coefficient fetch and operand select
    logic [CW-1:0]        ram_q;
    logic signed [CW-1:0] r2q_reg;
    logic                 r4vq_reg;
    logic                 v1_reg, ph1_reg;
    logic signed [PW-1:0] pa1_reg, pb1_reg, pc1_reg, pd1_reg;
    logic [3:0]           hit1_reg;   // a, b, c, d positions equal the component

    lpeg_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH4)
    ) u_r4_ram (
        .clk   (aclk),
        .we    (wr_r4),
        .waddr (coef_index[IDX4_W-1:0]),
        .wdata (coef_value),
        .raddr (idx_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        r2q_reg  <= r2_reg[idx_reg[IDX2_W-1:0]];
        r4vq_reg <= r4v_reg[idx_reg];
        ph1_reg  <= ph4_reg;
        pa1_reg  <= p_reg[a_reg];
        pb1_reg  <= p_reg[b_reg];
        pc1_reg  <= ph4_reg ? p_reg[c_reg] : '0;
        pd1_reg  <= ph4_reg ? p_reg[d_reg] : '0;
        hit1_reg <= {2'(d_reg) == m_reg, 2'(c_reg) == m_reg,
                     2'(b_reg) == m_reg, 2'(a_reg) == m_reg};
    end

    // stage 2: pair products
    logic signed [CW-1:0]   coef1;
    logic                   v2_reg, ph2_reg;
    logic signed [CW-1:0]   coef2_reg;
    logic signed [2*PW-1:0] pab2_reg, pcd2_reg;
    logic signed [PW-1:0]   pa2_reg, pb2_reg, pc2_reg, pd2_reg;
    logic [3:0]             hit2_reg;

    assign coef1 = ph1_reg ? (r4vq_reg ? $signed(ram_q) : '0) : r2q_reg;

    always_ff @(posedge aclk) begin
        coef2_reg <= coef1;
        ph2_reg   <= ph1_reg;
        pab2_reg  <= pa1_reg * pb1_reg;
        pcd2_reg  <= pc1_reg * pd1_reg;
        pa2_reg   <= pa1_reg;
        pb2_reg   <= pb1_reg;
        pc2_reg   <= pc1_reg;
        pd2_reg   <= pd1_reg;
        hit2_reg  <= hit1_reg;
    end

    // stage 3: quad and triple products
    logic                   v3_reg, ph3_reg;
    logic signed [CW-1:0]   coef3_reg;
    logic signed [4*PW-1:0] p4_3_reg;
    logic signed [3*PW-1:0] tabc3_reg, tabd3_reg, tacd3_reg, tbcd3_reg;
    logic signed [2*PW-1:0] pab3_reg;
    logic signed [PW-1:0]   pa3_reg, pb3_reg;
    logic [3:0]             hit3_reg;

    always_ff @(posedge aclk) begin
        coef3_reg <= coef2_reg;
        ph3_reg   <= ph2_reg;
        p4_3_reg  <= pab2_reg * pcd2_reg;
        tabc3_reg <= pab2_reg * pc2_reg;
        tabd3_reg <= pab2_reg * pd2_reg;
        tacd3_reg <= pcd2_reg * pa2_reg;
        tbcd3_reg <= pcd2_reg * pb2_reg;
        pab3_reg  <= pab2_reg;
        pa3_reg   <= pa2_reg;
        pb3_reg   <= pb2_reg;
        hit3_reg  <= hit2_reg;
    end

    // stage 4: rounding to q2.15 and lane weights
    logic signed [4*PW-1:0] r4_sum;
    logic signed [3*PW-1:0] rabc, rabd, racd, rbcd;
    logic signed [2*PW-1:0] r2_sum;
    logic signed [MW-1:0]   mono4, mono2, m_abc, m_abd, m_acd, m_bcd;
    logic signed [WW-1:0]   w_qe, w_fe, w_qg, w_fg;

    assign r4_sum = p4_3_reg + (64'sd1 <<< 44);
    assign rabc   = tabc3_reg + (48'sd1 <<< 29);
    assign rabd   = tabd3_reg + (48'sd1 <<< 29);
    assign racd   = tacd3_reg + (48'sd1 <<< 29);
    assign rbcd   = tbcd3_reg + (48'sd1 <<< 29);
    assign r2_sum = pab3_reg + (32'sd1 <<< 14);

    assign mono4 = r4_sum[61:45];
    assign m_abc = rabc[46:30];
    assign m_abd = rabd[46:30];
    assign m_acd = racd[46:30];
    assign m_bcd = rbcd[46:30];
    assign mono2 = r2_sum[31:15];

    always_comb begin
        w_qe = '0;
        w_fe = '0;
        w_qg = '0;
        w_fg = '0;
        if (ph3_reg) begin
            w_fe = WW'(mono4);
            // each index position holding the component contributes the other three
            if (hit3_reg[3]) w_fg = w_fg + WW'(m_abc);
            if (hit3_reg[2]) w_fg = w_fg + WW'(m_abd);
            if (hit3_reg[1]) w_fg = w_fg + WW'(m_acd);
            if (hit3_reg[0]) w_fg = w_fg + WW'(m_bcd);
        end else begin
            w_qe = WW'(mono2);
            if (hit3_reg[0]) w_qg = w_qg + WW'(pb3_reg);
            if (hit3_reg[1]) w_qg = w_qg + WW'(pa3_reg);
        end
    end

    logic                 v4_reg;
    logic signed [CW-1:0] coef4_reg;
    logic signed [WW-1:0] w4_reg [lpeg_pkg::NLANES];

    always_ff @(posedge aclk) begin
        coef4_reg                  <= coef3_reg;
        w4_reg[lpeg_pkg::LANE_QE]  <= w_qe;
        w4_reg[lpeg_pkg::LANE_FE]  <= w_fe;
        w4_reg[lpeg_pkg::LANE_QG]  <= w_qg;
        w4_reg[lpeg_pkg::LANE_FG]  <= w_fg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // accumulation lanes
    lpeg_pkg::lane_ctrl_t             lane_ctrl;
    lpeg_pkg::lane_stat_t             lane_stat [lpeg_pkg::NLANES];
    logic signed [lpeg_pkg::ACC_W-1:0] lane_acc [lpeg_pkg::NLANES];
    logic                             lanes_busy;

    assign lane_ctrl.clear = eval_start;
    assign lane_ctrl.valid = v4_reg;

    for (genvar g = 0; g < lpeg_pkg::NLANES; g++) begin : g_lane
        lpeg_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .coef    (coef4_reg),
            .wgt     (w4_reg[g]),
            .acc     (lane_acc[g]),
            .stat    (lane_stat[g])
        );
    end

    always_comb begin
        lanes_busy = 1'b0;
        for (int i = 0; i < lpeg_pkg::NLANES; i++) begin
            lanes_busy = lanes_busy | lane_stat[i].busy;
        end
    end

    // drain and hand off to the result register
    logic pipe_busy, out_free, out_load;

    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg || lanes_busy;
    assign out_load  = (state_reg == ST_DRAIN) && !pipe_busy && out_free;

    lpeg_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .qe       (lane_acc[lpeg_pkg::LANE_QE]),
        .fe       (lane_acc[lpeg_pkg::LANE_FE]),
        .qg       (lane_acc[lpeg_pkg::LANE_QG]),
        .fg       (lane_acc[lpeg_pkg::LANE_FG]),
        .free     (out_free),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (eval_start) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (issue_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // checks
    `LPEG_ASSERT_NXT(a_eval_start, aclk, aresetn, eval_start,
        state_reg == ST_RUN && idx_reg == '0 && !ph4_reg, "evaluate did not start sweep")
    `LPEG_ASSERT_IMP(a_load_empty, aclk, aresetn, out_load,
        !v1_reg && !v2_reg && !v3_reg && !v4_reg && !lanes_busy, "load with work in flight")
    `LPEG_ASSERT_IMP(a_no_issue_busy, aclk, aresetn, eval_start,
        !pipe_busy, "evaluate accepted while pipeline busy")

endmodule

`default_nettype wire
